// File: rtl/contact_tangent_basis_core_macros.svh
// Assertion macros shared by the contact basis checker.
`ifndef CONTACT_TANGENT_BASIS_CORE_MACROS_SVH
`define CONTACT_TANGENT_BASIS_CORE_MACROS_SVH

// Same-cycle implication, sampled on the block clock and disabled in reset.
`define CTB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("contact basis check failed");

// Next-cycle implication, sampled on the block clock and disabled in reset.
`define CTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("contact basis check failed");

`endif

// File: rtl/ctb_pkg.sv
// Package with the types, widths, constants and seed table of the contact basis core.
`timescale 1ns / 1ps
`default_nettype none

package ctb_pkg;

  // Field and datapath widths.
  localparam int COMP_W   = 16;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 32;
  localparam int Y_W      = 32;
  localparam int Y2_W     = 2 * Y_W - 30;
  localparam int T_W      = SUM_W + Y2_W - 32;
  localparam int K_W      = 4;
  localparam int MAG_W    = COMP_W + Y_W;
  localparam int SH_W     = 6;
  localparam int SEED_W   = 9;
  localparam int SEED_SHIFT = 22;

  // Parameter defaults.
  localparam int FRAC_BITS_DEF    = 14;
  localparam int NEWTON_STEPS_DEF = 2;

  // Pipeline depth of each unit.
  localparam int FRONT_STAGES  = 5;
  localparam int NEWTON_STAGES = 3;
  localparam int SCALE_STAGES  = 3;
  localparam int CROSS_STAGES  = 3;

  // Three in Q30, the constant term of the Newton step.
  localparam logic [Y_W-1:0] THREE_Q30 = Y_W'(3) << 30;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  // Item context that travels alongside the inverse square root.
  typedef struct packed {
    vec_t           n;
    logic           use_x;
    logic           degen;
    logic [K_W-1:0] k;
  } ctx_t;

  typedef struct packed {
    ctx_t             ctx;
    logic [SUM_W-1:0] m;
    logic [Y_W-1:0]   y;
  } nwt_t;

  typedef struct packed {
    vec_t n;
    logic degen;
    vec_t a;
  } tan_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    logic degen;
  } basis_t;

  // Q8 seed of 1/sqrt(x), indexed by the top four bits of the normalised sum.
  function automatic logic [SEED_W-1:0] seed_q8(input logic [3:0] idx);
    logic [SEED_W-1:0] val;
    unique case (idx)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: val = SEED_W'(483);
      4'd5:  val = SEED_W'(437);
      4'd6:  val = SEED_W'(402);
      4'd7:  val = SEED_W'(374);
      4'd8:  val = SEED_W'(351);
      4'd9:  val = SEED_W'(332);
      4'd10: val = SEED_W'(316);
      4'd11: val = SEED_W'(302);
      4'd12: val = SEED_W'(290);
      4'd13: val = SEED_W'(279);
      4'd14: val = SEED_W'(269);
      4'd15: val = SEED_W'(260);
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ctb_if.sv
// Valid/ready channel interfaces for the contact normal and the tangent basis.
`timescale 1ns / 1ps
`default_nettype none

interface ctb_normal_if import ctb_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t normal_x;
  comp_t normal_y;
  comp_t normal_z;

  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  input ready);
  modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                  output ready);
endinterface

interface ctb_basis_if import ctb_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t tangent_a_x;
  comp_t tangent_a_y;
  comp_t tangent_a_z;
  comp_t tangent_b_x;
  comp_t tangent_b_y;
  comp_t tangent_b_z;
  logic  degenerate;

  modport source (output valid, output tangent_a_x, output tangent_a_y,
                  output tangent_a_z, output tangent_b_x, output tangent_b_y,
                  output tangent_b_z, output degenerate, input ready);
  modport sink   (input valid, input tangent_a_x, input tangent_a_y,
                  input tangent_a_z, input tangent_b_x, input tangent_b_y,
                  input tangent_b_z, input degenerate, output ready);
endinterface

`default_nettype wire

// File: rtl/contact_tangent_basis_core.sv
// Top level of the contact tangent basis core: pipeline control and unit chain.
// The core takes one contact normal per cycle while its input is ready and returns the
// two tangents that complete an orthonormal basis, plus a flag for the zero normal.
// Its stages are axis choice, sum of squares, normalisation and seed lookup, three
// multiplier stages per Newton step, three for scaling and three for the cross
// product. Every stage carries a valid bit and has its own load enable, so a
// stalled output holds only the full stages with no empty stage between them and
// the output; empty stages ahead of a stall keep filling, and the input is ready
// whenever some stage between it and the output is empty or the output is being
// taken.
`timescale 1ns / 1ps
`default_nettype none

module contact_tangent_basis_core import ctb_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ctb_normal_if.sink         normal_i,
  ctb_basis_if.source        basis_o
);

  localparam int NWT_BASE   = FRONT_STAGES;
  localparam int SCALE_BASE = NWT_BASE + NEWTON_STEPS * NEWTON_STAGES;
  localparam int CROSS_BASE = SCALE_BASE + SCALE_STAGES;
  localparam int NST        = CROSS_BASE + CROSS_STAGES;

  logic [NST-1:0] vld_q, vld_d, vld_prev, en;
  vec_t           n_in;
  nwt_t           nwt_chain [NEWTON_STEPS+1];
  tan_t           tan;
  basis_t         bas;

  // A stage may load when the output is taken or some stage from it onwards is empty.
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = basis_o.ready | ~(&vld_q[NST-1:i]);
  end

  // Valid bits move with the data and hold where a stage is stalled.
  always_comb begin
    vld_prev = {vld_q[NST-2:0], normal_i.valid};
    vld_d    = (en & vld_prev) | (~en & vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign normal_i.ready = en[0];
  assign basis_o.valid  = vld_q[NST-1];

  assign n_in.x = normal_i.normal_x;
  assign n_in.y = normal_i.normal_y;
  assign n_in.z = normal_i.normal_z;

  // Front end up to the seed of the inverse square root.
  ctb_front u_front (
    .clk_i (clk_i),
    .en_i  (en[0 +: FRONT_STAGES]),
    .n_i   (n_in),
    .out_o (nwt_chain[0])
  );

  // Newton refinement, one unit per step.
  for (genvar j = 0; j < NEWTON_STEPS; j++) begin : g_newton
    ctb_newton u_newton (
      .clk_i (clk_i),
      .en_i  (en[NWT_BASE + j * NEWTON_STAGES +: NEWTON_STAGES]),
      .in_i  (nwt_chain[j]),
      .out_o (nwt_chain[j+1])
    );
  end

  ctb_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i (clk_i),
    .en_i  (en[SCALE_BASE +: SCALE_STAGES]),
    .in_i  (nwt_chain[NEWTON_STEPS]),
    .out_o (tan)
  );

  ctb_cross #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cross (
    .clk_i (clk_i),
    .en_i  (en[CROSS_BASE +: CROSS_STAGES]),
    .in_i  (tan),
    .out_o (bas)
  );

  assign basis_o.tangent_a_x = bas.a.x;
  assign basis_o.tangent_a_y = bas.a.y;
  assign basis_o.tangent_a_z = bas.a.z;
  assign basis_o.tangent_b_x = bas.b.x;
  assign basis_o.tangent_b_y = bas.b.y;
  assign basis_o.tangent_b_z = bas.b.z;
  assign basis_o.degenerate  = bas.degen;

endmodule

`default_nettype wire

// File: rtl/ctb_front.sv
// Front end: axis choice, sum of squares, even-shift normalisation and seed lookup.
`timescale 1ns / 1ps
`default_nettype none

module ctb_front import ctb_pkg::*; (
  input  logic                    clk_i,
  input  logic [FRONT_STAGES-1:0] en_i,
  input  vec_t                    n_i,
  output nwt_t                    out_o
);

  logic [COMP_W-1:0]        abs_x, abs_y;
  logic                     use_x;
  comp_t                    other;
  logic signed [2*COMP_W-1:0] sqz_full, sqo_full;

  vec_t             n1_q, n2_q, n3_q, n4_q;
  logic             use_x1_q, use_x2_q, use_x3_q, use_x4_q;
  logic [SQ_W-1:0]  sqz_q, sqo_q;
  logic [SUM_W-1:0] s_d, s2_q;
  logic             degen2_q, degen3_q, degen4_q;
  logic             hi16, hi8, hi4, hi2;
  logic [SUM_W-1:0] m3_a, m3_d, m3_q, m4_a, m4_d, m4_q;
  logic [K_W-1:0]   k3_q, k4_q;
  nwt_t             out_q;

  // Stage 1: pick the larger of |x| and |y| and square the two components.
  always_comb begin
    abs_x    = n_i.x[COMP_W-1] ? (~n_i.x + 1'b1) : n_i.x;
    abs_y    = n_i.y[COMP_W-1] ? (~n_i.y + 1'b1) : n_i.y;
    use_x    = abs_x > abs_y;
    other    = use_x ? n_i.x : n_i.y;
    sqz_full = n_i.z * n_i.z;
    sqo_full = other * other;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      n1_q     <= n_i;
      use_x1_q <= use_x;
      sqz_q    <= sqz_full[SQ_W-1:0];
      sqo_q    <= sqo_full[SQ_W-1:0];
    end
  end

  // Stage 2: sum of squares and the zero check.
  assign s_d = SUM_W'(sqz_q) + SUM_W'(sqo_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      n2_q     <= n1_q;
      use_x2_q <= use_x1_q;
      s2_q     <= s_d;
      degen2_q <= (s_d == '0);
    end
  end

  // Stage 3: coarse normalisation by 16 and 8 bits.
  always_comb begin
    hi16 = (s2_q[SUM_W-1 -: 16] == '0);
    m3_a = hi16 ? (s2_q << 16) : s2_q;
    hi8  = (m3_a[SUM_W-1 -: 8] == '0);
    m3_d = hi8 ? (m3_a << 8) : m3_a;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      n3_q     <= n2_q;
      use_x3_q <= use_x2_q;
      degen3_q <= degen2_q;
      m3_q     <= m3_d;
      k3_q     <= {hi16, hi8, 2'b00};
    end
  end

  // Stage 4: fine normalisation by 4 and 2 bits, so the sum lands in [2^30, 2^32).
  always_comb begin
    hi4  = (m3_q[SUM_W-1 -: 4] == '0);
    m4_a = hi4 ? (m3_q << 4) : m3_q;
    hi2  = (m4_a[SUM_W-1 -: 2] == '0);
    m4_d = hi2 ? (m4_a << 2) : m4_a;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      n4_q     <= n3_q;
      use_x4_q <= use_x3_q;
      degen4_q <= degen3_q;
      m4_q     <= m4_d;
      k4_q     <= {k3_q[K_W-1:2], hi4, hi2};
    end
  end

  // Stage 5: Q30 seed of the inverse square root from the table.
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      out_q.ctx.n     <= n4_q;
      out_q.ctx.use_x <= use_x4_q;
      out_q.ctx.degen <= degen4_q;
      out_q.ctx.k     <= k4_q;
      out_q.m         <= m4_q;
      out_q.y         <= Y_W'(seed_q8(m4_q[SUM_W-1 -: 4])) << SEED_SHIFT;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// File: rtl/ctb_newton.sv
// One Newton step of the inverse square root, spread over three multiplier stages.
`timescale 1ns / 1ps
`default_nettype none

module ctb_newton import ctb_pkg::*; (
  input  logic                     clk_i,
  input  logic [NEWTON_STAGES-1:0] en_i,
  input  nwt_t                     in_i,
  output nwt_t                     out_o
);

  logic [2*Y_W-1:0]       prod_yy;
  logic [SUM_W+Y2_W-1:0]  prod_my;
  logic [2*Y_W-1:0]       prod_yh;
  logic [T_W-1:0]         t_full;
  logic [Y_W-1:0]         h_d;

  nwt_t            s1_q, s2_q, out_q;
  logic [Y2_W-1:0] y2_q;
  logic [Y_W-1:0]  h_q;

  // Stage 1: y squared, back to Q30.
  assign prod_yy = in_i.y * in_i.y;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q <= in_i;
      y2_q <= prod_yy[2*Y_W-1:30];
    end
  end

  // Stage 2: m times y squared, then three minus that, floored at zero.
  always_comb begin
    prod_my = SUM_W'(s1_q.m) * Y2_W'(y2_q);
    t_full  = prod_my[SUM_W+Y2_W-1:32];
    h_d     = (t_full >= T_W'(THREE_Q30)) ? '0 : (THREE_Q30 - t_full[Y_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_q <= s1_q;
      h_q  <= h_d;
    end
  end

  // Stage 3: the refined estimate y * h / 2^31.
  assign prod_yh = s2_q.y * h_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      out_q.ctx <= s2_q.ctx;
      out_q.m   <= s2_q.m;
      out_q.y   <= prod_yh[Y_W+30:31];
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// File: rtl/ctb_scale.sv
// Scales the two source components by the inverse square root to form tangent a.
`timescale 1ns / 1ps
`default_nettype none

module ctb_scale import ctb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic [SCALE_STAGES-1:0] en_i,
  input  nwt_t                    in_i,
  output tan_t                    out_o
);

  // Total right shift is this base less the normalisation count k.
  localparam logic [SH_W-1:0]   SH_BASE = SH_W'(46 - FRAC_BITS);
  localparam logic [MAG_W-1:0]  MAG_LIM = MAG_W'(1) << (COMP_W - 1);
  localparam logic [COMP_W-1:0] POS_MAX = COMP_W'((1 << (COMP_W - 1)) - 1);

  comp_t             other;
  logic [COMP_W-1:0] abs_z, abs_o;

  ctx_t             ctx1_q, ctx2_q;
  logic [MAG_W-1:0] mag1_q, mag2_q;
  logic             neg1_q, neg2_q, neg1_2_q, neg2_2_q;

  logic [SH_W-1:0]   sh;
  logic [MAG_W-1:0]  rnd, r1, r2;
  logic [COMP_W-1:0] c1_q, c2_q;
  logic [COMP_W-1:0] a1, a2;
  tan_t              out_q;

  // Stage 1: magnitudes times y; the sign is kept apart.
  always_comb begin
    other = in_i.ctx.use_x ? in_i.ctx.n.x : in_i.ctx.n.y;
    abs_z = in_i.ctx.n.z[COMP_W-1] ? (~in_i.ctx.n.z + 1'b1) : in_i.ctx.n.z;
    abs_o = other[COMP_W-1] ? (~other + 1'b1) : other;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ctx1_q <= in_i.ctx;
      mag1_q <= MAG_W'(abs_z) * MAG_W'(in_i.y);
      mag2_q <= MAG_W'(abs_o) * MAG_W'(in_i.y);
      neg1_q <= in_i.ctx.n.z[COMP_W-1] ^ ~in_i.ctx.use_x;
      neg2_q <= other[COMP_W-1] ^ in_i.ctx.use_x;
    end
  end

  // Stage 2: round half away from zero on the magnitude and clamp to 2^15.
  always_comb begin
    sh  = SH_BASE - SH_W'(ctx1_q.k);
    rnd = MAG_W'(1) << (sh - SH_W'(1));
    r1  = (mag1_q + rnd) >> sh;
    r2  = (mag2_q + rnd) >> sh;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ctx2_q   <= ctx1_q;
      neg1_2_q <= neg1_q;
      neg2_2_q <= neg2_q;
      c1_q     <= (r1 > MAG_LIM) ? MAG_LIM[COMP_W-1:0] : r1[COMP_W-1:0];
      c2_q     <= (r2 > MAG_LIM) ? MAG_LIM[COMP_W-1:0] : r2[COMP_W-1:0];
    end
  end

  // Stage 3: apply the sign, saturate the positive edge, zero a degenerate item and place the components.
  always_comb begin
    if (neg1_2_q) begin
      a1 = ~c1_q + 1'b1;
    end else begin
      a1 = c1_q[COMP_W-1] ? POS_MAX : c1_q;
    end
    if (neg2_2_q) begin
      a2 = ~c2_q + 1'b1;
    end else begin
      a2 = c2_q[COMP_W-1] ? POS_MAX : c2_q;
    end
    if (ctx2_q.degen) begin
      a1 = '0;
      a2 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      out_q.n     <= ctx2_q.n;
      out_q.degen <= ctx2_q.degen;
      out_q.a.x   <= ctx2_q.use_x ? comp_t'(a1) : '0;
      out_q.a.y   <= ctx2_q.use_x ? '0 : comp_t'(a1);
      out_q.a.z   <= comp_t'(a2);
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// File: rtl/ctb_cross.sv
// Cross product of the normal with tangent a, rounded and saturated to tangent b.
`timescale 1ns / 1ps
`default_nettype none

module ctb_cross import ctb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic [CROSS_STAGES-1:0] en_i,
  input  tan_t                    in_i,
  output basis_t                  out_o
);

  localparam int P_W = 2 * COMP_W;
  localparam int D_W = P_W + 1;
  localparam int R_W = D_W + 1;
  localparam logic signed [R_W-1:0] HALF   = R_W'(64'sd1 << (FRAC_BITS - 1));
  localparam logic signed [R_W-1:0] SAT_HI = R_W'((1 << (COMP_W - 1)) - 1);
  localparam logic signed [R_W-1:0] SAT_LO = R_W'(-(1 << (COMP_W - 1)));

  tan_t                  s1_q, s2_q;
  logic signed [P_W-1:0] p_yaz_q, p_zay_q, p_zax_q, p_xaz_q, p_xay_q, p_yax_q;
  logic signed [D_W-1:0] dx_q, dy_q, dz_q;
  basis_t                out_q;

  // Round half away from zero by a biased arithmetic shift, then saturate.
  function automatic comp_t round_sat(input logic signed [D_W-1:0] d);
    logic signed [R_W-1:0] v;
    logic signed [R_W-1:0] r;
    comp_t                 res;
    v = R_W'(d);
    r = (v + (v[R_W-1] ? (HALF - R_W'(1)) : HALF)) >>> FRAC_BITS;
    if (r > SAT_HI) begin
      res = SAT_HI[COMP_W-1:0];
    end else if (r < SAT_LO) begin
      res = SAT_LO[COMP_W-1:0];
    end else begin
      res = r[COMP_W-1:0];
    end
    return res;
  endfunction

  // Stage 1: the six partial products.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q    <= in_i;
      p_yaz_q <= in_i.n.y * in_i.a.z;
      p_zay_q <= in_i.n.z * in_i.a.y;
      p_zax_q <= in_i.n.z * in_i.a.x;
      p_xaz_q <= in_i.n.x * in_i.a.z;
      p_xay_q <= in_i.n.x * in_i.a.y;
      p_yax_q <= in_i.n.y * in_i.a.x;
    end
  end

  // Stage 2: differences in Q(2*FRAC_BITS).
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_q <= s1_q;
      dx_q <= D_W'(p_yaz_q) - D_W'(p_zay_q);
      dy_q <= D_W'(p_zax_q) - D_W'(p_xaz_q);
      dz_q <= D_W'(p_xay_q) - D_W'(p_yax_q);
    end
  end

  // Stage 3: output register of the whole core.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      out_q.a     <= s2_q.a;
      out_q.degen <= s2_q.degen;
      out_q.b.x   <= round_sat(dx_q);
      out_q.b.y   <= round_sat(dy_q);
      out_q.b.z   <= round_sat(dz_q);
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// File: rtl/ctb_checker.sv
// Port-level assertion checker for the contact basis core, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "contact_tangent_basis_core_macros.svh"

module ctb_checker import ctb_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input comp_t ta_x_i,
  input comp_t ta_y_i,
  input comp_t ta_z_i,
  input comp_t tb_x_i,
  input comp_t tb_y_i,
  input comp_t tb_z_i,
  input logic  degenerate_i
);

  // The zero normal gives an all-zero basis.
  `CTB_ASSERT_IMPL(a_degen_zero, out_valid_i && degenerate_i, ta_x_i == '0 && ta_y_i == '0 && ta_z_i == '0 && tb_x_i == '0 && tb_y_i == '0 && tb_z_i == '0)

  // Tangent a always lies in the xz or the yz plane.
  `CTB_ASSERT_IMPL(a_tangent_plane, out_valid_i, ta_x_i == '0 || ta_y_i == '0)

  // With nothing waiting at the output the pipeline must take a new normal.
  `CTB_ASSERT_IMPL(a_ready_when_drained, !out_valid_i, in_ready_i)

  // A result that is not taken stays in place until its transfer.
  `CTB_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(ta_x_i) && $stable(ta_y_i) && $stable(ta_z_i) && $stable(tb_x_i) && $stable(tb_y_i) && $stable(tb_z_i) && $stable(degenerate_i))

endmodule

bind contact_tangent_basis_core ctb_checker u_ctb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (normal_i.ready),
  .out_valid_i  (basis_o.valid),
  .out_ready_i  (basis_o.ready),
  .ta_x_i       (basis_o.tangent_a_x),
  .ta_y_i       (basis_o.tangent_a_y),
  .ta_z_i       (basis_o.tangent_a_z),
  .tb_x_i       (basis_o.tangent_b_x),
  .tb_y_i       (basis_o.tangent_b_y),
  .tb_z_i       (basis_o.tangent_b_z),
  .degenerate_i (basis_o.degenerate)
);

`default_nettype wire
